/* sv/gcov_pkg.sv */
// shared types and constants of the greedy rectangle cover block
package gcov_pkg;

    localparam int GRID_SIDE_DEF = 8;
    localparam int ROW_W         = 8;
    localparam int RESULT_LIMIT  = 32;
    localparam int RANK_W        = 5;
    localparam int BS_W          = 13;
    localparam int GS_W          = 4;
    localparam int EDGE_W        = 16;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 1'b1;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 13'd16;
    localparam logic [GS_W-1:0] GRID_SIZE_RST  = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_CHK,
        ST_GROW_RD,
        ST_GROW_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [2:0]        x;
        logic [2:0]        z;
        logic [3:0]        w;
        logic [3:0]        h;
        logic [RANK_W-1:0] rank;
    } rect_t;

endpackage

/* sv/gcov_ram.sv */
// generic single-write, single-read ram with registered read data
module gcov_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/gcov_emit.sv */
// result stage: holds one rectangle back so the final one can carry last_rect
module gcov_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        new_valid,
    input  gcov_pkg::rect_t             new_rect,
    input  logic                        flush,
    input  logic [gcov_pkg::BS_W-1:0]   block_size,
    output logic                        rect_valid,
    output logic [2:0]                  rect_x,
    output logic [2:0]                  rect_z,
    output logic [3:0]                  rect_width,
    output logic [3:0]                  rect_height,
    output logic [gcov_pkg::EDGE_W-1:0] left_edge,
    output logic [gcov_pkg::EDGE_W-1:0] right_edge,
    output logic signed [gcov_pkg::EDGE_W-1:0] top_edge,
    output logic signed [gcov_pkg::EDGE_W-1:0] bottom_edge,
    output logic [8:0]                  base_vertex,
    output logic                        grid_empty,
    output logic                        last_rect
);
    import gcov_pkg::*;

    localparam int PROD_W = BS_W + 5;

    rect_t              pend_reg;
    logic               pend_valid_reg;
    logic               strobe_reg;
    logic               empty_reg;
    logic               last_reg;
    rect_t              out_reg;
    logic [EDGE_W-1:0]  left_reg, right_reg, top_reg, bottom_reg;
    logic [PROD_W-1:0]  p_left, p_right, p_top, p_bottom;
    logic               emit;

    // edge products of the held rectangle
    always_comb
    begin
        p_left   = PROD_W'(block_size) * PROD_W'(pend_reg.x);
        p_right  = PROD_W'(block_size) * (PROD_W'(pend_reg.x) + PROD_W'(pend_reg.w));
        p_top    = PROD_W'(block_size) * PROD_W'(pend_reg.z);
        p_bottom = PROD_W'(block_size) * (PROD_W'(pend_reg.z) + PROD_W'(pend_reg.h));
    end

    assign emit = (new_valid && pend_valid_reg) || flush;

    // hold register and output transaction registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            empty_reg      <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
            if (emit)
            begin
                empty_reg <= flush && !pend_valid_reg;
                last_reg  <= flush;
            end
            if (flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (new_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // payload, zero for the empty grid
    always_ff @(posedge clk)
    begin
        if (new_valid)
        begin
            pend_reg <= new_rect;
        end
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_reg    <= pend_reg;
                left_reg   <= p_left[EDGE_W-1:0];
                right_reg  <= p_right[EDGE_W-1:0];
                top_reg    <= EDGE_W'(0) - p_top[EDGE_W-1:0];
                bottom_reg <= EDGE_W'(0) - p_bottom[EDGE_W-1:0];
            end
            else
            begin
                out_reg    <= '0;
                left_reg   <= '0;
                right_reg  <= '0;
                top_reg    <= '0;
                bottom_reg <= '0;
            end
        end
    end

    assign rect_valid  = strobe_reg;
    assign rect_x      = out_reg.x;
    assign rect_z      = out_reg.z;
    assign rect_width  = out_reg.w;
    assign rect_height = out_reg.h;
    assign left_edge   = left_reg;
    assign right_edge  = right_reg;
    assign top_edge    = top_reg;
    assign bottom_edge = bottom_reg;
    assign base_vertex = {1'b0, out_reg.rank, 3'b000};
    assign grid_empty  = empty_reg;
    assign last_rect   = last_reg;

    // an empty result always closes the extraction
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        rect_valid && grid_empty |-> last_rect && rect_width == 4'd0)
        else $error("empty result without last_rect");

    // the last result of an extraction is followed by a quiet cycle
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        rect_valid && last_rect |=> !rect_valid)
        else $error("result right after last_rect");

    // a flush always produces a result in the next cycle
    a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
        flush |=> rect_valid && last_rect)
        else $error("flush without result");

endmodule

/* sv/greedy_rectangle_cover_core.sv */
// top level: row loading, greedy cover sequencer and grid memories
//
// Rows load one per cycle: start with busy low accepts a row. A row with
// last_row set starts extraction; busy then stays high until the final
// result. Configuration writes are held off (cfg_ready low) while busy.
// The sequencer walks the cells with x outer and z inner, reading
// one grid row from the solid and visited memories per access, with
// registered read data. Each cell takes a read and a check state, each
// row of rectangle growth a read and a check state and each row marked
// visited a read and a write state; a flush state ends the extraction.
// Results appear on rect_valid for one cycle each; the receiver cannot
// stall them. The visited rows are cleared at once through per-row valid
// bits, so no clearing pass exists.
module greedy_rectangle_cover_core #(
    parameter int GRID_SIDE = gcov_pkg::GRID_SIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gcov_pkg::ROW_W-1:0]     row_bits,
    input  logic                           last_row,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gcov_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gcov_pkg::BS_W-1:0]      cfg_data,
    output logic                           rect_valid,
    output logic [2:0]                     rect_x,
    output logic [2:0]                     rect_z,
    output logic [3:0]                     rect_width,
    output logic [3:0]                     rect_height,
    output logic [gcov_pkg::EDGE_W-1:0]    left_edge,
    output logic [gcov_pkg::EDGE_W-1:0]    right_edge,
    output logic signed [gcov_pkg::EDGE_W-1:0] top_edge,
    output logic signed [gcov_pkg::EDGE_W-1:0] bottom_edge,
    output logic [8:0]                     base_vertex,
    output logic                           grid_empty,
    output logic                           last_rect
);
    import gcov_pkg::*;

    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam int CNT_W = $clog2(GRID_SIDE + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     x_reg, x_next, z_reg, z_next, r_reg, r_next;
    logic [CNT_W-1:0]     w_reg, w_next, h_reg, h_next;
    logic [CNT_W-1:0]     n_reg, n_next, rows_reg, rows_next;
    logic [RANK_W-1:0]    count_reg, count_next;
    logic [BS_W-1:0]      bs_reg;
    logic [GS_W-1:0]      gs_reg;
    logic [GRID_SIDE-1:0] vvalid_reg, vvalid_next;
    logic [IDX_W-1:0]     rd_addr_reg;

    logic                 accept;
    logic [IDX_W-1:0]     raddr;
    logic                 solid_we, vis_we;
    logic [ROW_W-1:0]     solid_rdata, vis_rdata, vis_eff, free_row, span_mask;
    logic [CNT_W-1:0]     w_calc, n_clamp;
    logic                 z_last, x_last, grow_ok, rect_done, full;
    logic                 new_valid, flush;
    rect_t                new_rect;
    logic [SUM_W-1:0]     pos, zh;

    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= BLOCK_SIZE_RST;
            gs_reg <= GRID_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE: bs_reg <= cfg_data;
                CFG_GRID_SIZE:  gs_reg <= cfg_data[GS_W-1:0];
                default:        ;
            endcase
        end
    end

    // grid side in use
    always_comb
    begin
        priority if (gs_reg == '0)
            n_clamp = CNT_W'(1);
        else if (gs_reg > GS_W'(GRID_SIDE))
            n_clamp = CNT_W'(GRID_SIDE);
        else
            n_clamp = CNT_W'(gs_reg);
    end

    // free cells of the row just read
    assign vis_eff  = vvalid_reg[rd_addr_reg] ? vis_rdata : '0;
    assign free_row = solid_rdata & ~vis_eff;

    // run length along x from the current cell
    always_comb
    begin
        logic go;
        go     = 1'b1;
        w_calc = CNT_W'(1);
        pos    = '0;
        for (int d = 1; d < GRID_SIDE; d++)
        begin
            pos = SUM_W'(x_reg) + SUM_W'(d);
            if (go && pos < SUM_W'(n_reg) && free_row[pos[IDX_W-1:0]])
                w_calc = w_calc + CNT_W'(1);
            else
                go = 1'b0;
        end
    end

    // span of the current rectangle along x
    always_comb
    begin
        span_mask = '0;
        for (int i = 0; i < GRID_SIDE; i++)
        begin
            span_mask[i] = (SUM_W'(i) >= SUM_W'(x_reg)) &&
                           (SUM_W'(i) < SUM_W'(x_reg) + SUM_W'(w_reg));
        end
    end

    assign grow_ok   = (free_row & span_mask) == span_mask;
    assign zh        = SUM_W'(z_reg) + SUM_W'(h_reg);
    assign z_last    = SUM_W'(z_reg) + SUM_W'(1) >= SUM_W'(n_reg);
    assign x_last    = SUM_W'(x_reg) + SUM_W'(1) >= SUM_W'(n_reg);
    assign rect_done = SUM_W'(r_reg) + SUM_W'(1) == zh;
    assign full      = count_reg == RANK_W'(RESULT_LIMIT - 1);

    // next state and sequencer datapath
    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        z_next      = z_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        n_next      = n_reg;
        rows_next   = rows_reg;
        count_next  = count_reg;
        vvalid_next = vvalid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (rows_reg < CNT_W'(GRID_SIDE))
                        rows_next = rows_reg + CNT_W'(1);
                    if (last_row)
                    begin
                        state_next  = ST_CELL_RD;
                        x_next      = '0;
                        z_next      = '0;
                        count_next  = '0;
                        n_next      = n_clamp;
                        vvalid_next = '0;
                    end
                end
            end
            ST_CELL_RD:
                state_next = ST_CELL_CHK;
            ST_CELL_CHK:
            begin
                if (free_row[x_reg])
                begin
                    w_next = w_calc;
                    h_next = CNT_W'(1);
                    r_next = z_reg;
                    state_next = z_last ? ST_MARK_RD : ST_GROW_RD;
                end
                else if (!z_last)
                begin
                    z_next = z_reg + IDX_W'(1);
                    state_next = ST_CELL_RD;
                end
                else if (!x_last)
                begin
                    x_next = x_reg + IDX_W'(1);
                    z_next = '0;
                    state_next = ST_CELL_RD;
                end
                else
                    state_next = ST_FLUSH;
            end
            ST_GROW_RD:
                state_next = ST_GROW_CHK;
            ST_GROW_CHK:
            begin
                if (grow_ok)
                begin
                    h_next = h_reg + CNT_W'(1);
                    state_next = (zh + SUM_W'(1) < SUM_W'(n_reg)) ? ST_GROW_RD : ST_MARK_RD;
                end
                else
                    state_next = ST_MARK_RD;
            end
            ST_MARK_RD:
                state_next = ST_MARK_WR;
            ST_MARK_WR:
            begin
                vvalid_next[r_reg] = 1'b1;
                if (!rect_done)
                begin
                    r_next = r_reg + IDX_W'(1);
                    state_next = ST_MARK_RD;
                end
                else
                begin
                    count_next = count_reg + RANK_W'(1);
                    if (full)
                        state_next = ST_FLUSH;
                    else if (!z_last)
                    begin
                        z_next = z_reg + IDX_W'(1);
                        state_next = ST_CELL_RD;
                    end
                    else if (!x_last)
                    begin
                        x_next = x_reg + IDX_W'(1);
                        z_next = '0;
                        state_next = ST_CELL_RD;
                    end
                    else
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                rows_next  = '0;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory controls and result handoff
    always_comb
    begin
        busy      = state_reg != ST_IDLE;
        solid_we  = accept && (rows_reg < CNT_W'(GRID_SIDE));
        vis_we    = state_reg == ST_MARK_WR;
        new_valid = (state_reg == ST_MARK_WR) && rect_done;
        flush     = state_reg == ST_FLUSH;
        unique case (state_reg)
            ST_GROW_RD: raddr = zh[IDX_W-1:0];
            ST_MARK_RD: raddr = r_reg;
            default:    raddr = z_reg;
        endcase
    end

    assign new_rect.x    = 3'(x_reg);
    assign new_rect.z    = 3'(z_reg);
    assign new_rect.w    = 4'(w_reg);
    assign new_rect.h    = 4'(h_reg);
    assign new_rect.rank = count_reg;

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            x_reg       <= '0;
            z_reg       <= '0;
            r_reg       <= '0;
            w_reg       <= '0;
            h_reg       <= '0;
            n_reg       <= '0;
            rows_reg    <= '0;
            count_reg   <= '0;
            vvalid_reg  <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            x_reg       <= x_next;
            z_reg       <= z_next;
            r_reg       <= r_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            n_reg       <= n_next;
            rows_reg    <= rows_next;
            count_reg   <= count_next;
            vvalid_reg  <= vvalid_next;
            rd_addr_reg <= raddr;
        end
    end

    // grid memories
    gcov_ram #(.WIDTH(ROW_W), .DEPTH(GRID_SIDE)) u_solid (
        .clk   (clk),
        .we    (solid_we),
        .waddr (rows_reg[IDX_W-1:0]),
        .wdata (row_bits),
        .raddr (raddr),
        .rdata (solid_rdata)
    );

    gcov_ram #(.WIDTH(ROW_W), .DEPTH(GRID_SIDE)) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (r_reg),
        .wdata (vis_eff | span_mask),
        .raddr (raddr),
        .rdata (vis_rdata)
    );

    gcov_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .new_valid   (new_valid),
        .new_rect    (new_rect),
        .flush       (flush),
        .block_size  (bs_reg),
        .rect_valid  (rect_valid),
        .rect_x      (rect_x),
        .rect_z      (rect_z),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .left_edge   (left_edge),
        .right_edge  (right_edge),
        .top_edge    (top_edge),
        .bottom_edge (bottom_edge),
        .base_vertex (base_vertex),
        .grid_empty  (grid_empty),
        .last_rect   (last_rect)
    );

    // a final row always leads to extraction
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_row |=> busy)
        else $error("final row did not start extraction");

    // rows are never counted past the grid side
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg <= CNT_W'(GRID_SIDE))
        else $error("row counter overflow");

    // the visited memory is written only at rows inside the grid in use
    a_mark_row: assert property (@(posedge clk) disable iff (!rst_n)
        vis_we |-> SUM_W'(r_reg) < SUM_W'(n_reg))
        else $error("visited write outside grid");

endmodule
